// File: rtl/ates_pkg.sv
// Shared types and constants for the array table edit/sort/search block.
// Command and status codes, field widths and the controller state type.
// No dependencies.
package ates_pkg;

  localparam int unsigned MODE_W   = 3;
  localparam int unsigned POS_W    = 8;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 8;

  typedef enum logic [MODE_W-1:0] {
    MODE_CLEAR   = 3'd0,
    MODE_INSERT  = 3'd1,
    MODE_DELETE  = 3'd2,
    MODE_READ    = 3'd3,
    MODE_SORT_UP = 3'd4,
    MODE_SORT_DN = 3'd5,
    MODE_SEARCH  = 3'd6
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE    = 2'd0,
    ST_BAD_POS = 2'd1,
    ST_FULL    = 2'd2
  } status_e;

  typedef enum logic [12:0] {
    S_IDLE   = 13'b0000000000001,
    S_INS_R  = 13'b0000000000010,
    S_INS_W  = 13'b0000000000100,
    S_DEL_R  = 13'b0000000001000,
    S_DEL_W  = 13'b0000000010000,
    S_RD_W   = 13'b0000000100000,
    S_SRC_R  = 13'b0000001000000,
    S_SRC_C  = 13'b0000010000000,
    S_SRT_I  = 13'b0000100000000,
    S_SRT_A  = 13'b0001000000000,
    S_SRT_JR = 13'b0010000000000,
    S_SRT_JC = 13'b0100000000000,
    S_FIN    = 13'b1000000000000
  } state_e;

endpackage

// File: rtl/array_table_edit_sort_search.sv
// Top level of the array table edit/sort/search block: command controller,
// entry count and result register. Depends on ates_pkg and ates_ram.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+--------------------------------------
//  in      | input     | in_valid_i / in_stall_o | mode_i, position_i, value_i
//  out     | output    | out_valid_o/out_stall_i | status_o, found_o, read_value_o, count_o
//
// One command at a time; RAM reads are registered, so each step issues a read and then uses the data.
// Reset clears the count and control; the table itself needs no clearing pass.
// A new command is taken while the previous result still waits in the output beat.
module array_table_edit_sort_search #(
  parameter int unsigned TABLE_DEPTH = 128
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [ates_pkg::MODE_W-1:0]     mode_i,
  input  logic [ates_pkg::POS_W-1:0]      position_i,
  input  logic signed [ates_pkg::DATA_W-1:0] value_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [ates_pkg::STATUS_W-1:0]   status_o,
  output logic                            found_o,
  output logic signed [ates_pkg::DATA_W-1:0] read_value_o,
  output logic [ates_pkg::COUNT_W-1:0]    count_o
);

  import ates_pkg::*;

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned PW = (CW > POS_W) ? CW : POS_W;

  state_e                   state_q, state_d;
  logic [CW-1:0]            cnt_q, cnt_d;
  logic [CW-1:0]            idx_q, idx_d;
  logic [CW-1:0]            stop_q, stop_d;
  logic [CW-1:0]            j_q, j_d;
  logic signed [DATA_W-1:0] val_q, val_d;
  logic signed [DATA_W-1:0] ai_q, ai_d;
  logic                     desc_q, desc_d;
  status_e                  res_status_q, res_status_d;
  logic                     res_found_q, res_found_d;
  logic signed [DATA_W-1:0] res_rd_q, res_rd_d;

  logic                     out_valid_q;
  logic [STATUS_W-1:0]      out_status_q;
  logic                     out_found_q;
  logic signed [DATA_W-1:0] out_rd_q;
  logic [COUNT_W-1:0]       out_count_q;

  logic                     ram_we, ram_re;
  logic [AW-1:0]            ram_waddr, ram_raddr;
  logic [DATA_W-1:0]        ram_wdata, ram_rdata;
  logic signed [DATA_W-1:0] rd_s;

  logic [PW-1:0]            pos_ext, cnt_ext;
  logic [CW-1:0]            idx_inc, idx_dec, j_inc, cnt_dec;
  logic                     accept, out_free, full, swap;

  ates_ram #(
    .WIDTH (DATA_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rd_s     = $signed(ram_rdata);
  assign pos_ext  = PW'(position_i);
  assign cnt_ext  = PW'(cnt_q);
  assign idx_inc  = idx_q + CW'(1);
  assign idx_dec  = idx_q - CW'(1);
  assign j_inc    = j_q + CW'(1);
  assign cnt_dec  = cnt_q - CW'(1);
  assign full     = (cnt_q == CW'(TABLE_DEPTH));
  assign in_stall_o = (state_q != S_IDLE);
  assign accept   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;
  assign swap     = desc_q ? (rd_s > ai_q) : (ai_q > rd_s);

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    idx_d        = idx_q;
    stop_d       = stop_q;
    j_d          = j_q;
    val_d        = val_q;
    ai_d         = ai_q;
    desc_d       = desc_q;
    res_status_d = res_status_q;
    res_found_d  = res_found_q;
    res_rd_d     = res_rd_q;
    ram_we       = 1'b0;
    ram_waddr    = idx_q[AW-1:0];
    ram_wdata    = ram_rdata;
    ram_re       = 1'b0;
    ram_raddr    = idx_q[AW-1:0];

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          res_status_d = ST_DONE;
          res_found_d  = 1'b0;
          res_rd_d     = '0;
          val_d        = value_i;
          desc_d       = (mode_e'(mode_i) == MODE_SORT_DN);
          state_d      = S_FIN;
          unique case (mode_e'(mode_i))
            MODE_CLEAR: begin
              cnt_d = '0;
            end
            MODE_INSERT: begin
              if (pos_ext > cnt_ext) begin
                res_status_d = ST_BAD_POS;
              end else if (full) begin
                res_status_d = ST_FULL;
              end else begin
                idx_d   = cnt_q;
                stop_d  = CW'(pos_ext);
                state_d = S_INS_R;
              end
            end
            MODE_DELETE: begin
              if (pos_ext >= cnt_ext) begin
                res_status_d = ST_BAD_POS;
              end else begin
                idx_d   = CW'(pos_ext);
                state_d = S_DEL_R;
              end
            end
            MODE_READ: begin
              if (pos_ext >= cnt_ext) begin
                res_status_d = ST_BAD_POS;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = pos_ext[AW-1:0];
                state_d   = S_RD_W;
              end
            end
            MODE_SORT_UP, MODE_SORT_DN: begin
              if (cnt_q >= CW'(2)) begin
                idx_d   = '0;
                state_d = S_SRT_I;
              end
            end
            MODE_SEARCH: begin
              idx_d   = '0;
              state_d = S_SRC_R;
            end
            default: begin
              state_d = S_FIN;
            end
          endcase
        end
      end
      S_INS_R: begin
        if (idx_q == stop_q) begin
          ram_we    = 1'b1;
          ram_wdata = $unsigned(val_q);
          cnt_d     = cnt_q + CW'(1);
          state_d   = S_FIN;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = idx_dec[AW-1:0];
          state_d   = S_INS_W;
        end
      end
      S_INS_W: begin
        ram_we  = 1'b1;
        idx_d   = idx_dec;
        state_d = S_INS_R;
      end
      S_DEL_R: begin
        if (idx_inc >= cnt_q) begin
          cnt_d   = cnt_dec;
          state_d = S_FIN;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = idx_inc[AW-1:0];
          state_d   = S_DEL_W;
        end
      end
      S_DEL_W: begin
        ram_we  = 1'b1;
        idx_d   = idx_inc;
        state_d = S_DEL_R;
      end
      S_RD_W: begin
        res_rd_d = rd_s;
        state_d  = S_FIN;
      end
      S_SRC_R: begin
        if (idx_q >= cnt_q) begin
          state_d = S_FIN;
        end else begin
          ram_re  = 1'b1;
          state_d = S_SRC_C;
        end
      end
      S_SRC_C: begin
        if (rd_s == val_q) begin
          res_found_d = 1'b1;
          state_d     = S_FIN;
        end else begin
          idx_d   = idx_inc;
          state_d = S_SRC_R;
        end
      end
      S_SRT_I: begin
        ram_re  = 1'b1;
        j_d     = idx_inc;
        state_d = S_SRT_A;
      end
      S_SRT_A: begin
        ai_d    = rd_s;
        state_d = S_SRT_JR;
      end
      S_SRT_JR: begin
        if (j_q >= cnt_q) begin
          ram_we    = 1'b1;
          ram_wdata = $unsigned(ai_q);
          idx_d     = idx_inc;
          state_d   = (idx_inc >= cnt_dec) ? S_FIN : S_SRT_I;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = j_q[AW-1:0];
          state_d   = S_SRT_JC;
        end
      end
      S_SRT_JC: begin
        if (swap) begin
          ram_we    = 1'b1;
          ram_waddr = j_q[AW-1:0];
          ram_wdata = $unsigned(ai_q);
          ai_d      = rd_s;
        end
        j_d     = j_inc;
        state_d = S_SRT_JR;
      end
      S_FIN: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (state_q == S_FIN && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q        <= idx_d;
    stop_q       <= stop_d;
    j_q          <= j_d;
    val_q        <= val_d;
    ai_q         <= ai_d;
    desc_q       <= desc_d;
    res_status_q <= res_status_d;
    res_found_q  <= res_found_d;
    res_rd_q     <= res_rd_d;
    if (state_q == S_FIN && out_free) begin
      out_status_q <= res_status_q;
      out_found_q  <= res_found_q;
      out_rd_q     <= res_rd_q;
      out_count_q  <= COUNT_W'(cnt_q);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = out_status_q;
  assign found_o      = out_found_q;
  assign read_value_o = out_rd_q;
  assign count_o      = out_count_q;

endmodule

// File: rtl/ates_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// Used for the entry table. No dependencies.
module ates_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: verif/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for array_table_edit_sort_search: queued commands,
// a random-idling driver and stalling monitor, and a table predictor in SV.
// Depends on ates_pkg and the block's RTL.
module testbench;
  import ates_pkg::*;

  localparam int DEPTH     = 128;
  localparam int ITEMS     = 950;
  localparam int CALM_TAIL = 80;
  localparam int QUIET_MAX = 200000;
  localparam int DRAIN     = 20;

  localparam logic [MODE_W-1:0]        MODE_UNUSED = 3'd7;
  localparam logic signed [DATA_W-1:0] WORD_MIN    = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] WORD_MAX    = 32'sh7fff_ffff;

  typedef struct {
    logic [MODE_W-1:0]        mode;
    logic [POS_W-1:0]         pos;
    logic signed [DATA_W-1:0] value;
  } command_t;

  typedef struct {
    status_e                  status;
    logic                     found;
    logic signed [DATA_W-1:0] rd;
    logic [COUNT_W-1:0]       cnt;
  } outcome_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                     in_valid_i = 1'b0;
  logic                     in_stall_o;
  logic [MODE_W-1:0]        mode_i = '0;
  logic [POS_W-1:0]         position_i = '0;
  logic signed [DATA_W-1:0] value_i = '0;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  logic [STATUS_W-1:0]      status_o;
  logic                     found_o;
  logic signed [DATA_W-1:0] read_value_o;
  logic [COUNT_W-1:0]       count_o;

  command_t command_q [$];
  outcome_t outcome_q [$];

  logic signed [DATA_W-1:0] table_mirror [DEPTH];
  int held_n = 0;
  int plan_n = 0;

  int errors = 0;
  int n_cmds = 0;
  int n_checked = 0;
  int n_sorts = 0;
  int n_hits = 0;
  int n_full = 0;

  array_table_edit_sort_search #(
    .TABLE_DEPTH(DEPTH)
  ) i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .mode_i      (mode_i),
    .position_i  (position_i),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_o    (status_o),
    .found_o     (found_o),
    .read_value_o(read_value_o),
    .count_o     (count_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic int count_after(logic [MODE_W-1:0] m, int p, int n);
    case (m)
      MODE_CLEAR:  return 0;
      MODE_INSERT: return (p <= n && n < DEPTH) ? n + 1 : n;
      MODE_DELETE: return (p < n) ? n - 1 : n;
      default:     return n;
    endcase
  endfunction

  function automatic void apply_command(logic [MODE_W-1:0] m, logic [POS_W-1:0] pos,
                                        logic signed [DATA_W-1:0] v);
    outcome_t r;
    int p;
    logic signed [DATA_W-1:0] t;
    logic swap;
    p = pos;
    r.status = ST_DONE;
    r.found = 1'b0;
    r.rd = '0;
    n_cmds++;
    case (m)
      MODE_INSERT: begin
        if (p > held_n) begin
          r.status = ST_BAD_POS;
        end else if (held_n >= DEPTH) begin
          r.status = ST_FULL;
          n_full++;
        end else begin
          for (int i = held_n; i > p; i--) table_mirror[i] = table_mirror[i-1];
          table_mirror[p] = v;
        end
      end
      MODE_DELETE: begin
        if (p >= held_n) r.status = ST_BAD_POS;
        else for (int i = p; i + 1 < held_n; i++) table_mirror[i] = table_mirror[i+1];
      end
      MODE_READ: begin
        if (p >= held_n) r.status = ST_BAD_POS;
        else r.rd = table_mirror[p];
      end
      MODE_SORT_UP, MODE_SORT_DN: begin
        n_sorts++;
        for (int i = 0; i + 1 < held_n; i++) begin
          for (int j = i + 1; j < held_n; j++) begin
            swap = (m == MODE_SORT_UP) ? (table_mirror[i] > table_mirror[j])
                                       : (table_mirror[j] > table_mirror[i]);
            if (swap) begin
              t = table_mirror[i];
              table_mirror[i] = table_mirror[j];
              table_mirror[j] = t;
            end
          end
        end
      end
      MODE_SEARCH: begin
        for (int i = 0; i < held_n; i++) if (table_mirror[i] == v) r.found = 1'b1;
        if (r.found) n_hits++;
      end
      default: ;
    endcase
    held_n = count_after(m, p, held_n);
    r.cnt = held_n[COUNT_W-1:0];
    outcome_q.push_back(r);
  endfunction

  function automatic void push_cmd(logic [MODE_W-1:0] m, int p, logic signed [DATA_W-1:0] v);
    command_t c;
    c.mode = m;
    c.pos = p[POS_W-1:0];
    c.value = v;
    command_q.push_back(c);
    plan_n = count_after(m, int'(c.pos), plan_n);
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_value();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 4) return $urandom;
    if (sel < 8) return int'($urandom_range(0, 16)) - 8;
    case ($urandom_range(0, 4))
      0: return WORD_MIN;
      1: return WORD_MAX;
      2: return WORD_MIN + 1;
      3: return -1;
      default: return 0;
    endcase
  endfunction

  // Mostly a legal position below limit, sometimes one from limit up to 255.
  function automatic int pick_pos(int limit);
    if (limit == 0 || $urandom_range(0, 7) == 0) return $urandom_range(limit, 255);
    return $urandom_range(0, limit - 1);
  endfunction

  // Driver
  int in_gap = 0;
  int in_rate = 0;
  int in_cyc = 0;
  command_t nxt;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_gap = 0;
    end else begin
      in_cyc++;
      if (in_cyc % 256 == 0) in_rate = $urandom_range(0, 3);
      if (in_valid_i && !in_stall_o) apply_command(mode_i, position_i, value_i);
      if (!in_valid_i || !in_stall_o) begin
        if (in_gap != 0) begin
          in_gap--;
          in_valid_i <= 1'b0;
        end else if (command_q.size() > CALM_TAIL && in_rate != 0 &&
                     $urandom_range(0, 7) < in_rate) begin
          in_gap = $urandom_range(0, 14);
          in_valid_i <= 1'b0;
        end else if (command_q.size() != 0) begin
          nxt = command_q.pop_front();
          in_valid_i <= 1'b1;
          mode_i <= nxt.mode;
          position_i <= nxt.pos;
          value_i <= nxt.value;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor
  int stall_left = 0;
  int out_rate = 0;
  int out_cyc = 0;
  outcome_t want;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left = 0;
    end else begin
      out_cyc++;
      if (out_cyc % 256 == 128) out_rate = $urandom_range(0, 3);
      if (out_valid_o && !out_stall_i) begin
        if (outcome_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected beat, expected none, got status %0d count %0d",
                   $time, status_o, count_o);
        end else begin
          want = outcome_q.pop_front();
          n_checked++;
          if (status_o !== want.status) begin
            errors++;
            $display("%0t: status expected %0d, got %0d", $time, want.status, status_o);
          end
          if (found_o !== want.found) begin
            errors++;
            $display("%0t: found expected %0d, got %0d", $time, want.found, found_o);
          end
          if (read_value_o !== want.rd) begin
            errors++;
            $display("%0t: read_value expected %0d, got %0d", $time, want.rd, read_value_o);
          end
          if (count_o !== want.cnt) begin
            errors++;
            $display("%0t: count expected %0d, got %0d", $time, want.cnt, count_o);
          end
        end
      end
      if (stall_left != 0) stall_left--;
      else if (command_q.size() > CALM_TAIL && out_rate != 0 &&
               $urandom_range(0, 7) < out_rate) stall_left = $urandom_range(1, 15);
      out_stall_i <= (stall_left != 0);
    end
  end

  // Watchdog
  int quiet = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet = 0;
      else quiet++;
      if (quiet == QUIET_MAX) begin
        $display("%0t: no beat for %0d cycles", $time, QUIET_MAX);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    int fill;
    int sel;
    bit big;

    // empty table, short sorts, extremes, bad positions
    push_cmd(MODE_READ, 0, 0);
    push_cmd(MODE_DELETE, 0, 0);
    push_cmd(MODE_INSERT, 1, 5);
    push_cmd(MODE_SORT_UP, 0, 0);
    push_cmd(MODE_INSERT, 0, WORD_MIN);
    push_cmd(MODE_SORT_DN, 0, 0);
    push_cmd(MODE_INSERT, 1, WORD_MAX);
    push_cmd(MODE_INSERT, 1, 0);
    push_cmd(MODE_INSERT, 0, -1);
    push_cmd(MODE_READ, 3, 0);
    push_cmd(MODE_READ, 4, 0);
    push_cmd(MODE_READ, 255, WORD_MAX);
    push_cmd(MODE_SEARCH, 0, WORD_MIN);
    push_cmd(MODE_SEARCH, 255, 7);
    push_cmd(MODE_SORT_UP, 0, 0);
    push_cmd(MODE_READ, 0, 0);
    push_cmd(MODE_READ, 3, 0);
    push_cmd(MODE_SORT_DN, 0, 0);
    push_cmd(MODE_READ, 0, 0);
    push_cmd(MODE_READ, 3, 0);
    push_cmd(MODE_DELETE, 3, 0);
    push_cmd(MODE_DELETE, 0, 0);
    push_cmd(MODE_DELETE, 2, 0);
    push_cmd(MODE_UNUSED, 255, -1);
    push_cmd(MODE_CLEAR, 128, WORD_MIN);

    while (command_q.size() < ITEMS) begin
      push_cmd(MODE_CLEAR, $urandom_range(0, 255), $urandom);
      big = ($urandom_range(0, 11) == 0);
      fill = big ? DEPTH : $urandom_range(0, 24);
      repeat (fill) push_cmd(MODE_INSERT, plan_n, pick_value());
      if (big) begin
        push_cmd(MODE_INSERT, $urandom_range(0, DEPTH), pick_value());
        push_cmd(MODE_INSERT, $urandom_range(DEPTH + 1, 255), pick_value());
      end
      repeat ($urandom_range(10, 40)) begin
        sel = $urandom_range(0, 99);
        if (sel < 25) push_cmd(MODE_INSERT, pick_pos(plan_n + 1), pick_value());
        else if (sel < 45) push_cmd(MODE_DELETE, pick_pos(plan_n), $urandom);
        else if (sel < 68) push_cmd(MODE_READ, pick_pos(plan_n), $urandom);
        else if (sel < 84) push_cmd(MODE_SEARCH, $urandom_range(0, 255), pick_value());
        else if (sel < 88) push_cmd(MODE_SORT_UP, $urandom_range(0, 255), $urandom);
        else if (sel < 92) push_cmd(MODE_SORT_DN, $urandom_range(0, 255), $urandom);
        else if (sel < 95) push_cmd(MODE_UNUSED, $urandom_range(0, 255), $urandom);
        else if (sel < 97) push_cmd(MODE_CLEAR, $urandom_range(0, 255), $urandom);
        else push_cmd(MODE_INSERT, plan_n, pick_value());
      end
    end

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (command_q.size() != 0 || in_valid_i || outcome_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);

    $display("Ran %0d commands and checked %0d results: %0d sorts, %0d search hits,",
             n_cmds, n_checked, n_sorts, n_hits);
    $display("%0d inserts refused on a full table, random idling on both channels",
             n_full);
    if (errors == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule
